@@ hdl/rolling_window_variance_macros.svh @@
// Assertion macros for the rolling window variance block
`ifndef ROLLING_WINDOW_VARIANCE_MACROS_SVH
`define ROLLING_WINDOW_VARIANCE_MACROS_SVH
`ifndef SYNTHESIS
`define RWV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RWV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RWV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RWV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/rwv_pkg.sv @@
package rwv_pkg;
    localparam int MAX_WINDOW_DEF = 256;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W = 9;
    localparam int SUM_W = 25;
    localparam int SQ_W = 39;
    localparam int VAR_W = 39;
    localparam int FRAC_BITS = 8;
    localparam int NUM_W = 48;
    localparam int DEN_W = 17;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd16;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_job;
endpackage

@@ hdl/rolling_window_variance.sv @@
// Sliding-window sample variance.
// Input channel: i_valid / o_stall carry a word of i_sample (signed 16 bit)
// and i_restart (start a new series with this sample).
// Output channel: o_valid / i_stall carry o_variance, unsigned UQ31.8,
// the unbiased variance of the last window_length samples, truncated.
// No word is produced until the window holds window_length samples.
// Configuration: i_cfg_we writes window_length (i_cfg_data) and clears
// the series; write only while the block is idle. Reset length is 16.
// The front end accepts a sample when idle, then runs ring read, update
// and output (numerator product, queue push) before the next; ring
// storage is one RAM with registered read. The back end runs a
// restoring divider, one quotient bit per cycle, over the numerator
// shifted up by 8 bits, and holds each result until i_stall is low
// before it takes the next job. A two-entry queue parts the two ends.
// Synchronous reset clears counts, sums and queue; ring contents need
// no clearing. While i_stall is high the result is held and the queue
// fills; o_stall is high whenever the front end is not idle.
module rolling_window_variance
    import rwv_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [LEN_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [VAR_W-1:0]           o_variance
);
`include "rolling_window_variance_macros.svh"

    logic w_push, w_full, w_pop, w_qvalid, w_busy;
    t_job w_job, w_qjob;

    rwv_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_stall,
        .i_sample, .i_restart,
        .o_job_valid (w_push),
        .o_job       (w_job),
        .i_job_full  (w_full),
        .o_busy      (w_busy)
    );

    rwv_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (w_push), .i_data (w_job), .o_full (w_full),
        .i_pop (w_pop), .o_valid (w_qvalid), .o_data (w_qjob)
    );

    rwv_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid (w_qvalid), .i_job (w_qjob), .o_job_pop (w_pop),
        .o_valid, .i_stall, .o_variance
    );

    `RWV_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_full, !w_push)
    `RWV_ASSERT_IMP(a_pop_has_data, i_clk, i_rst_n, w_pop, w_qvalid)
    `RWV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                    o_valid && $stable(o_variance))
    `RWV_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, o_stall, w_busy)
endmodule

@@ hdl/rwv_ram.sv @@
module rwv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/rwv_front.sv @@
module rwv_front
    import rwv_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [LEN_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    output logic                       o_job_valid,
    output t_job                       o_job,
    input  logic                       i_job_full,
    output logic                       o_busy
);
    localparam int MAX_WINDOW = MAX_WINDOW_DEF;
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int MULW = SQ_W + WW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [LEN_W-1:0]           r_len;
    logic [WW-1:0]              r_pos, n_pos;
    logic [WW-1:0]              r_fill, n_fill;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [SQ_W-1:0]            r_sq, n_sq;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic                       r_emit;
    logic [WW-1:0]              w_eff;
    logic [SAMPLE_W-1:0]        w_old;
    logic                       w_we;
    logic signed [2*SAMPLE_W-1:0] w_sq_new, w_sq_old;
    logic [MULW-1:0]            w_wsq;
    logic signed [2*SUM_W-1:0]  w_s2;
    logic [WW-1:0]              w_pos_cur, w_fill_cur;

    always_comb begin
        if (r_len < LEN_W'(2)) begin
            w_eff = WW'(2);
        end else if (r_len > LEN_W'(MAX_WINDOW)) begin
            w_eff = WW'(MAX_WINDOW);
        end else begin
            w_eff = WW'(r_len);
        end
    end

    assign w_pos_cur  = (r_pos >= w_eff) ? '0 : r_pos;
    assign w_fill_cur = r_fill;
    assign w_we = (r_state == S_UPD);

    rwv_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pos_cur[AW-1:0]),
        .i_wdata (r_smp),
        .i_raddr (w_pos_cur[AW-1:0]),
        .o_rdata (w_old)
    );

    assign w_sq_new = r_smp * r_smp;
    assign w_sq_old = $signed(w_old) * $signed(w_old);
    assign w_wsq = MULW'(r_sq) * MULW'(w_eff);
    assign w_s2 = r_sum * r_sum;

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_fill = r_fill;
        n_sum = r_sum;
        n_sq = r_sq;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                    if (i_restart) begin
                        n_pos = '0;
                        n_fill = '0;
                        n_sum = '0;
                        n_sq = '0;
                    end
                end
            end
            S_READ: n_state = S_UPD;
            S_UPD: begin
                n_state = S_OUT;
                if (w_fill_cur >= w_eff) begin
                    n_sum = r_sum - SUM_W'($signed(w_old)) + SUM_W'(r_smp);
                    n_sq = r_sq - SQ_W'(w_sq_old) + SQ_W'(w_sq_new);
                end else begin
                    n_sum = r_sum + SUM_W'(r_smp);
                    n_sq = r_sq + SQ_W'(w_sq_new);
                    n_fill = r_fill + WW'(1);
                end
                n_pos = (w_pos_cur + WW'(1) >= w_eff) ? '0 : w_pos_cur + WW'(1);
            end
            S_OUT: begin
                if (!r_emit || !i_job_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_pos = '0;
            n_fill = '0;
            n_sum = '0;
            n_sq = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= LEN_RESET;
            r_pos <= '0;
            r_fill <= '0;
            r_sum <= '0;
            r_sq <= '0;
            r_emit <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_fill <= n_fill;
            r_sum <= n_sum;
            r_sq <= n_sq;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (r_state == S_UPD) begin
                r_emit <= (n_fill >= w_eff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_smp <= i_sample;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_OUT) && r_emit && !i_job_full;
    assign o_job.num = NUM_W'(w_wsq) - NUM_W'(w_s2);
    assign o_job.den = DEN_W'(w_eff) * DEN_W'(w_eff - WW'(1));
    assign o_busy = (r_state != S_IDLE);
endmodule

@@ hdl/rwv_queue.sv @@
module rwv_queue
    import rwv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
endmodule

@@ hdl/rwv_back.sv @@
module rwv_back
    import rwv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VAR_W-1:0] o_variance
);
    localparam int DIV_W = NUM_W + FRAC_BITS;
    localparam int CW = $clog2(DIV_W + 1);

    logic [1:0]         r_st;
    logic [DIV_W-1:0]   r_q;
    logic [DEN_W:0]     r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [CW-1:0]      r_cnt;
    logic [VAR_W-1:0]   r_out;
    logic [DEN_W:0]     w_trial;
    logic [DEN_W+1:0]   w_diff;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    assign w_trial = {r_rem[DEN_W-1:0], r_q[DIV_W-1]};
    assign w_diff = {1'b0, w_trial} - {2'b0, r_den};
    assign o_job_pop = (r_st == B_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                B_IDLE: if (i_job_valid) begin
                    r_st <= B_DIV;
                    r_cnt <= CW'(DIV_W);
                end
                B_DIV: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_st <= B_OUT;
                    end
                end
                B_OUT: if (!i_stall) begin
                    r_st <= B_IDLE;
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == B_IDLE && i_job_valid) begin
            r_q <= {i_job.num, FRAC_BITS'(0)};
            r_den <= i_job.den;
            r_rem <= '0;
        end else if (r_st == B_DIV) begin
            if (!w_diff[DEN_W+1]) begin
                r_rem <= w_diff[DEN_W:0];
                r_q <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q <= {r_q[DIV_W-2:0], 1'b0};
            end
            if (r_cnt == CW'(1)) begin
                r_out <= (!w_diff[DEN_W+1]) ? VAR_W'({r_q[DIV_W-2:0], 1'b1})
                                             : VAR_W'({r_q[DIV_W-2:0], 1'b0});
            end
        end
    end

    assign o_valid = (r_st == B_OUT);
    assign o_variance = r_out;
endmodule

@@ sim/testbench.sv @@
module testbench;
    import rwv_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } t_word;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [LEN_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_restart;
    logic                       o_valid;
    logic                       i_stall;
    logic [VAR_W-1:0]           o_variance;

    rolling_window_variance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .i_restart(i_restart),
        .o_valid(o_valid), .i_stall(i_stall), .o_variance(o_variance)
    );

    // predictor state
    logic signed [SAMPLE_W-1:0] win_ring [0:255];
    int unsigned                win_pos;
    int unsigned                win_fill;
    longint                     win_sum;
    longint unsigned            win_sqsum;
    int unsigned                win_len;

    t_word               pending_words[$];
    logic [VAR_W-1:0]    expected_variance[$];
    int                  mismatch_count;
    int                  send_gap;
    int                  recv_gap;
    bit                  hold_off;
    bit                  cfg_busy;

    function automatic int unsigned clamp_len(int unsigned v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return v;
    endfunction

    task automatic clear_window();
        win_pos = 0;
        win_fill = 0;
        win_sum = 0;
        win_sqsum = 0;
    endtask

    task automatic predict_variance(t_word wd);
        int unsigned     w;
        longint          s;
        longint          old;
        longint unsigned num;
        longint unsigned den;
        w = clamp_len(win_len);
        s = wd.sample;
        if (wd.restart) clear_window();
        if (win_pos >= w) win_pos = 0;
        if (win_fill >= w) begin
            old = win_ring[win_pos];
            win_sum -= old;
            win_sqsum -= longint'(old * old);
        end
        win_ring[win_pos] = wd.sample;
        win_sum += s;
        win_sqsum += longint'(s * s);
        win_pos++;
        if (win_pos >= w) win_pos = 0;
        if (win_fill < w) win_fill++;
        if (win_fill < w) return;
        num = longint'(w) * win_sqsum - longint'(win_sum * win_sum);
        den = longint'(w) * longint'(w - 1);
        expected_variance.push_back(VAR_W'((num << FRAC_BITS) / den));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !o_stall) begin
            predict_variance('{i_sample, i_restart});
            if (send_gap == 0 && pending_words.size() > 0 && !cfg_busy) begin
                i_sample <= pending_words[0].sample;
                i_restart <= pending_words[0].restart;
                void'(pending_words.pop_front());
                send_gap <= $urandom_range(0, 13) * ($urandom_range(0, 3) == 0);
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_words.size() > 0 && !cfg_busy) begin
                i_valid <= 1'b1;
                i_sample <= pending_words[0].sample;
                i_restart <= pending_words[0].restart;
                void'(pending_words.pop_front());
                send_gap <= $urandom_range(0, 13) * ($urandom_range(0, 3) == 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_variance.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: variance %0d", o_variance);
                end else begin
                    if (o_variance !== expected_variance[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("variance mismatch: expected %0d actual %0d",
                                     expected_variance[0], o_variance);
                    end
                    void'(expected_variance.pop_front());
                end
                recv_gap <= $urandom_range(0, 13) * ($urandom_range(0, 3) == 0);
            end
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (recv_gap > 0 && !(o_valid && !i_stall)) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (o_valid && !i_stall) ?
                           ($urandom_range(0, 3) == 0) : 1'b0;
            end
        end
    end

    task automatic queue_word(int s, bit r);
        t_word wd;
        wd.sample = SAMPLE_W'(s);
        wd.restart = r;
        pending_words.push_back(wd);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || i_valid || expected_variance.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_length(int unsigned len);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= LEN_W'(len);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_len = len;
        clear_window();
    endtask

    initial begin
        int unsigned lens[6];
        int unsigned w;
        int          n;
        int          mode;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_sample = '0;
        i_restart = 1'b0;
        i_stall = 1'b0;
        hold_off = 1'b0;
        cfg_busy = 1'b0;
        mismatch_count = 0;
        win_len = LEN_RESET;
        clear_window();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset length 16, extremes, restart mid-series
        for (int i = 0; i < 18; i++) queue_word((i % 2) ? 32767 : -32768, i == 0);
        queue_word(0, 1);
        queue_word(-1, 0);
        queue_word(12345, 0);
        for (int i = 0; i < 4; i++) queue_word(-32768, 0);
        wait_idle();

        lens = '{2, 256, 3, 1, 300, 7};
        for (int p = 0; p < 6; p++) begin
            write_length(lens[p]);
            w = clamp_len(lens[p]);
            n = (w > 100) ? 330 : 170;
            for (int i = 0; i < n; i++) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) queue_word($urandom_range(0, 1) ? 32767 : -32768, 0);
                else if (mode == 1) queue_word(int'($urandom_range(0, 20)) - 10, 0);
                else queue_word(int'($urandom_range(0, 65535)) - 32768,
                                $urandom_range(0, 60) == 0);
            end
            if (p == 0) begin
                // long hold-off on the result side while words keep coming
                repeat (20) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_variance.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
